### design/dlfd_pkg.sv
// shared types and constants for the decimal length frame deframer
package dlfd_pkg;

    // default width of the length accumulator and byte counter
    localparam int unsigned LEN_WIDTH_DEF = 16;

    // configuration register map
    localparam int unsigned ADDR_W            = 3;
    localparam int unsigned DATA_W            = 32;
    localparam int unsigned CFG_W             = 16;
    localparam logic [0:0]  REG_MAX_FRAME_LEN = 1'b0;
    localparam logic [CFG_W-1:0] MAX_FRAME_LEN_RST = 16'd4096;

    // characters of the frame syntax
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // field numbering inside the payload
    localparam logic [2:0] FIELD_SRC = 3'd0;
    localparam logic [2:0] FIELD_CRC = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_DIGIT  = 3'd2;
    localparam logic [2:0] ERR_LEN    = 3'd3;
    localparam logic [2:0] ERR_FIELDS = 3'd4;

    // one result beat
    typedef struct packed {
        logic [7:0] byte_out;
        logic       is_payload;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       is_separator;
        logic [2:0] field_index;
        logic [2:0] error_code;
    } t_result;

endpackage

### design/dlfd_core.sv
// frame parser state machine with its result register and handshake
module dlfd_core #(
    parameter int unsigned LEN_WIDTH = dlfd_pkg::LEN_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dlfd_pkg::CFG_W-1:0] i_max_frame_len,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_data_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output dlfd_pkg::t_result          o_result
);

    // compare width wide enough for both the length and the limit
    localparam int unsigned CMP_W = (LEN_WIDTH > dlfd_pkg::CFG_W) ? LEN_WIDTH
                                                                 : dlfd_pkg::CFG_W;

    typedef enum logic [2:0] {
        PH_HUNT_R,
        PH_EXPECT_G,
        PH_EXPECT_COMMA,
        PH_LENGTH,
        PH_PAYLOAD
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [LEN_WIDTH-1:0] r_acc, n_acc;
    logic [LEN_WIDTH-1:0] r_rem, n_rem;
    logic [2:0]           r_comma, n_comma;
    logic                 r_first, n_first;
    logic                 r_out_valid;
    dlfd_pkg::t_result    r_result, n_result;

    logic                 accept;
    logic                 is_digit;
    logic [LEN_WIDTH+3:0] acc_times_ten;
    logic [CMP_W-1:0]     acc_cmp;
    logic [CMP_W-1:0]     limit_cmp;

    // a new beat can enter whenever the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // length digit accumulate: acc*10 + digit as two shifts and adds
    assign is_digit      = (i_data_byte >= dlfd_pkg::CH_ZERO) &&
                           (i_data_byte <= dlfd_pkg::CH_NINE);
    assign acc_times_ten = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                         + {{LEN_WIDTH{1'b0}}, i_data_byte[3:0]};
    assign acc_cmp       = CMP_W'(r_acc);
    assign limit_cmp     = CMP_W'(i_max_frame_len);

    // next state and result for the incoming byte
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_comma  = r_comma;
        n_first  = r_first;
        n_result = '0;
        n_result.byte_out   = i_data_byte;
        n_result.error_code = dlfd_pkg::ERR_NONE;
        case (r_phase)
            PH_HUNT_R: begin
                n_phase = (i_data_byte == dlfd_pkg::CH_R) ? PH_EXPECT_G : PH_HUNT_R;
            end
            PH_EXPECT_G: begin
                if (i_data_byte == dlfd_pkg::CH_G) begin
                    n_phase = PH_EXPECT_COMMA;
                end else begin
                    n_result.error_code = dlfd_pkg::ERR_MAGIC;
                    n_phase = (i_data_byte == dlfd_pkg::CH_R) ? PH_EXPECT_G : PH_HUNT_R;
                end
            end
            PH_EXPECT_COMMA: begin
                if (i_data_byte == dlfd_pkg::CH_COMMA) begin
                    n_phase = PH_LENGTH;
                    n_acc   = '0;
                end else begin
                    n_result.error_code = dlfd_pkg::ERR_MAGIC;
                    n_phase = (i_data_byte == dlfd_pkg::CH_R) ? PH_EXPECT_G : PH_HUNT_R;
                end
            end
            PH_LENGTH: begin
                if (is_digit) begin
                    // saturate at all ones when the product overflows
                    if (acc_times_ten[LEN_WIDTH+3:LEN_WIDTH] != 4'd0) begin
                        n_acc = '1;
                    end else begin
                        n_acc = acc_times_ten[LEN_WIDTH-1:0];
                    end
                end else if (i_data_byte == dlfd_pkg::CH_COMMA) begin
                    if ((r_acc == '0) || (acc_cmp > limit_cmp)) begin
                        n_result.error_code = dlfd_pkg::ERR_LEN;
                        n_phase = PH_HUNT_R;
                    end else begin
                        n_rem   = r_acc;
                        n_comma = dlfd_pkg::FIELD_SRC;
                        n_first = 1'b1;
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_result.error_code = dlfd_pkg::ERR_DIGIT;
                    n_phase = PH_HUNT_R;
                end
            end
            PH_PAYLOAD: begin
                n_result.is_payload     = 1'b1;
                n_result.first_of_frame = r_first;
                n_result.field_index    = r_comma;
                n_first = 1'b0;
                // only the first four commas split fields
                if ((i_data_byte == dlfd_pkg::CH_COMMA) && (r_comma < dlfd_pkg::FIELD_CRC)) begin
                    n_result.is_separator = 1'b1;
                    n_comma = r_comma + 3'd1;
                end
                if (r_rem != '0) begin
                    n_rem = r_rem - LEN_WIDTH'(1);
                end
                if (r_rem <= LEN_WIDTH'(1)) begin
                    n_result.last_of_frame = 1'b1;
                    if (n_comma < dlfd_pkg::FIELD_CRC) begin
                        n_result.error_code = dlfd_pkg::ERR_FIELDS;
                    end
                    n_phase = PH_HUNT_R;
                end
            end
            default: begin
                n_phase = PH_HUNT_R;
            end
        endcase
    end

    // parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT_R;
            r_acc       <= '0;
            r_rem       <= '0;
            r_comma     <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_rem       <= n_rem;
                r_comma     <= n_comma;
                r_first     <= n_first;
                r_result    <= n_result;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### design/decimal_length_frame_deframer_top.sv
// top level of the decimal length frame deframer with its register port
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------------------
//  input     | in        | i_in_valid / o_in_ready    | i_data_byte
//  result    | out       | o_out_valid / i_out_ready  | o_byte_out .. o_error_code
//  register  | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
//  each byte is parsed on acceptance and its result is registered, so one
//  beat per cycle flows when the result side keeps up.
//  the result beat appears in the cycle after its input beat is accepted.
//  a stalled result holds the register; input ready follows result ready.
//  synchronous active-low reset puts the parser back to hunting for R and
//  sets max_frame_len to 4096.
module decimal_length_frame_deframer_top #(
    parameter int unsigned LEN_WIDTH = dlfd_pkg::LEN_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_data_byte,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_byte_out,
    output logic                        o_is_payload,
    output logic                        o_first_of_frame,
    output logic                        o_last_of_frame,
    output logic                        o_is_separator,
    output logic [2:0]                  o_field_index,
    output logic [2:0]                  o_error_code,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dlfd_pkg::ADDR_W-1:0] paddr,
    input  logic [dlfd_pkg::DATA_W-1:0] pwdata,
    output logic [dlfd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic [dlfd_pkg::CFG_W-1:0] r_max_frame_len;
    logic                       reg_write;
    logic                       reg_sel;
    dlfd_pkg::t_result          result;

    // register decode on the word index
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == dlfd_pkg::REG_MAX_FRAME_LEN);
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_len <= dlfd_pkg::MAX_FRAME_LEN_RST;
        end else if (reg_write && reg_sel) begin
            r_max_frame_len <= pwdata[dlfd_pkg::CFG_W-1:0];
        end
    end

    // read back
    assign prdata = reg_sel ? dlfd_pkg::DATA_W'(r_max_frame_len) : '0;

    // parser
    dlfd_core #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_frame_len (r_max_frame_len),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result        (result)
    );

    // result fields to ports
    assign o_byte_out       = result.byte_out;
    assign o_is_payload     = result.is_payload;
    assign o_first_of_frame = result.first_of_frame;
    assign o_last_of_frame  = result.last_of_frame;
    assign o_is_separator   = result.is_separator;
    assign o_field_index    = result.field_index;
    assign o_error_code     = result.error_code;

endmodule

### design/dlfd_checker.sv
// port-level checks for the deframer, bound to the top level
module dlfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_data_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_byte_out,
    input logic       o_is_payload,
    input logic       o_first_of_frame,
    input logic       o_last_of_frame,
    input logic       o_is_separator,
    input logic [2:0] o_field_index
);

    // an accepted beat shows up as the next result with its byte echoed
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (o_out_valid && (o_byte_out == $past(i_data_byte))))
        else $error("accepted byte not echoed on the next result");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_byte_out)))
        else $error("stalled result changed");

    // an empty result register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    // marks outside the payload stay clear
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_payload) |->
            (!o_first_of_frame && !o_last_of_frame && !o_is_separator &&
             (o_field_index == 3'd0)))
        else $error("payload mark on a non-payload byte");

endmodule

bind decimal_length_frame_deframer_top dlfd_checker u_dlfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_data_byte      (i_data_byte),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_byte_out       (o_byte_out),
    .o_is_payload     (o_is_payload),
    .o_first_of_frame (o_first_of_frame),
    .o_last_of_frame  (o_last_of_frame),
    .o_is_separator   (o_is_separator),
    .o_field_index    (o_field_index)
);
